>>> rtl/dsr_pkg.sv
`timescale 1ns / 1ps

package dsr_pkg;

    localparam int STORE_DEPTH_DEF  = 256;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int SECONDS_W   = 16;
    localparam int DEPTH_W     = 16;
    localparam int INDEX_W     = 8;
    localparam int READ_W      = 16;
    localparam int FILL_OUT_W  = 9;
    localparam int INTERVAL_W  = 8;
    localparam int DELAY_W     = 8;
    localparam int INIT_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [INTERVAL_W-1:0] INTERVAL_LIMIT = 8'd127;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd2;
    localparam logic [DELAY_W-1:0]    DELAY_RESET    = 8'd5;
    localparam logic [INIT_W-1:0]     INIT_RESET     = 7'd2;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY   = 2'd0,
        CFG_INIT_INTERVAL = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_STARTED   = 2'd1,
        PH_RECORDING = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMP,
        ST_COMP_END,
        ST_APPEND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic tick;
        logic read;
        logic comp_start;
        logic comp_rd;
        logic comp_finish;
        logic append;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic sample_due;
        logic need_comp;
        logic full;
        logic comp_last;
    } t_dp_status;

endpackage

>>> rtl/dsr_ctrl.sv
`timescale 1ns / 1ps

module dsr_ctrl import dsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.is_read) begin
                    o_cmd.read = 1'b1;
                    n_state    = ST_DONE;
                end else begin
                    o_cmd.tick = 1'b1;
                    priority if (i_status.sample_due && i_status.need_comp) begin
                        o_cmd.comp_start = 1'b1;
                        n_state          = ST_COMP;
                    end else if (i_status.sample_due && !i_status.full) begin
                        n_state = ST_APPEND;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_COMP: begin
                o_cmd.comp_rd = 1'b1;
                if (i_status.comp_last) begin
                    n_state = ST_COMP_END;
                end
            end
            ST_COMP_END: begin
                o_cmd.comp_finish = 1'b1;
                n_state           = ST_APPEND;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/dsr_datapath.sv
`timescale 1ns / 1ps

module dsr_datapath import dsr_pkg::*; #(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_operation,
    input  logic                  i_in_dive,
    input  logic [SECONDS_W-1:0]  i_dive_seconds,
    input  logic [DEPTH_W-1:0]    i_depth_decimeters,
    input  logic [INDEX_W-1:0]    i_read_index,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [READ_W-1:0]     o_read_value,
    output logic [FILL_OUT_W-1:0] o_fill_count,
    output logic [INTERVAL_W-1:0] o_interval_ticks,
    output logic                  o_recording,
    output logic                  o_sample_written
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int FW   = $clog2(STORE_DEPTH + 1);
    localparam int HALF = STORE_DEPTH / 2;
    localparam int KW   = AW - 1;
    localparam int CW   = (FW > INDEX_W) ? FW : INDEX_W;
    localparam int XW   = (SAMPLE_WIDTH > DEPTH_W) ? SAMPLE_WIDTH : DEPTH_W;

    localparam logic [FW-1:0]           FILL_FULL  = FW'(STORE_DEPTH);
    localparam logic [FW-1:0]           FILL_HALF  = FW'(HALF);
    localparam logic [FW-1:0]           FILL_ONE   = FW'(1);
    localparam logic [KW-1:0]           K_LAST     = KW'(HALF - 1);
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = '1;

    logic [SAMPLE_WIDTH-1:0] r_mem [0:STORE_DEPTH-1];

    t_op                     r_op;
    logic                    r_in_dive;
    logic [SECONDS_W-1:0]    r_seconds;
    logic [DEPTH_W-1:0]      r_depth;
    logic [INDEX_W-1:0]      r_index;

    logic [DELAY_W-1:0]      r_start_delay;
    logic [INIT_W-1:0]       r_init_interval;
    logic [FW-1:0]           r_fill;
    logic [INTERVAL_W-1:0]   r_interval;
    logic [INTERVAL_W-1:0]   r_tick;
    t_phase                  r_phase;
    logic                    r_written;
    logic                    r_read_ok;
    logic [KW-1:0]           r_k;
    logic                    r_cw_valid;
    logic [KW-1:0]           r_cw_idx;
    logic [SAMPLE_WIDTH-1:0] r_qa;
    logic [SAMPLE_WIDTH-1:0] r_qb;

    logic [INTERVAL_W-1:0]   tick_next;
    logic                    tick_hit;
    logic                    nonidle;
    logic                    start_ok;
    logic                    full;
    logic [CW-1:0]           idx_ext;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic [SAMPLE_WIDTH:0]   pair_sum;
    logic [SAMPLE_WIDTH-1:0] pair_avg;
    logic [XW-1:0]           depth_ext;
    logic [SAMPLE_WIDTH-1:0] depth_sat;
    logic                    we;
    logic [AW-1:0]           wa;
    logic [SAMPLE_WIDTH-1:0] wd;

    assign tick_next = r_tick + INTERVAL_W'(1);
    assign tick_hit  = tick_next >= r_interval;
    assign nonidle   = r_phase != PH_IDLE;
    assign start_ok  = r_in_dive && (r_seconds >= SECONDS_W'(r_start_delay));
    assign full      = r_fill == FILL_FULL;
    assign idx_ext   = CW'(r_index);

    assign o_status.is_read    = r_op == OP_READ;
    assign o_status.sample_due = nonidle && r_in_dive && tick_hit;
    assign o_status.need_comp  = full && (r_interval < INTERVAL_LIMIT);
    assign o_status.full       = full;
    assign o_status.comp_last  = r_k == K_LAST;

    assign rd_addr_a = i_cmd.read ? idx_ext[AW-1:0] : {r_k, 1'b0};
    assign rd_addr_b = {r_k, 1'b1};

    // pair average, a nonzero sum never rounds down to zero
    always_comb begin
        pair_sum = {1'b0, r_qa} + {1'b0, r_qb};
        pair_avg = pair_sum[SAMPLE_WIDTH:1];
        if (pair_sum == (SAMPLE_WIDTH + 1)'(1)) begin
            pair_avg = SAMPLE_WIDTH'(1);
        end
    end

    always_comb begin
        depth_ext = XW'(r_depth);
        if (depth_ext > XW'(SAMPLE_MAX)) begin
            depth_sat = SAMPLE_MAX;
        end else begin
            depth_sat = depth_ext[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        priority if (r_cw_valid) begin
            we = 1'b1;
            wa = AW'(r_cw_idx);
            wd = pair_avg;
        end else if (i_cmd.append) begin
            we = 1'b1;
            wa = r_fill[AW-1:0];
            wd = depth_sat;
        end else if (i_cmd.tick && !nonidle && start_ok) begin
            we = 1'b1;
        end else begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_cmd.read || i_cmd.comp_rd) begin
            r_qa <= r_mem[rd_addr_a];
            r_qb <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= t_op'(i_operation);
            r_in_dive <= i_in_dive;
            r_seconds <= i_dive_seconds;
            r_depth   <= i_depth_decimeters;
            r_index   <= i_read_index;
        end
        r_cw_idx <= r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay   <= DELAY_RESET;
            r_init_interval <= INIT_RESET;
            r_fill          <= '0;
            r_interval      <= INTERVAL_RESET;
            r_tick          <= '0;
            r_phase         <= PH_IDLE;
            r_written       <= 1'b0;
            r_read_ok       <= 1'b0;
            r_k             <= '0;
            r_cw_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_DELAY:   r_start_delay   <= i_cfg_data;
                    CFG_INIT_INTERVAL: r_init_interval <= i_cfg_data[INIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            r_cw_valid <= i_cmd.comp_rd;
            if (i_cmd.comp_start) begin
                r_k <= '0;
            end else if (i_cmd.comp_rd) begin
                r_k <= r_k + KW'(1);
            end

            if (i_cmd.read) begin
                r_read_ok <= nonidle && (idx_ext < CW'(r_fill));
                r_written <= 1'b0;
            end

            if (i_cmd.tick) begin
                r_read_ok <= 1'b0;
                r_written <= 1'b0;
                if (!nonidle) begin
                    if (start_ok) begin
                        r_tick     <= '0;
                        r_interval <= INTERVAL_W'(r_init_interval);
                        r_phase    <= PH_STARTED;
                        r_fill     <= FILL_ONE;
                    end else begin
                        r_tick <= tick_next;
                    end
                end else if (r_in_dive) begin
                    r_phase <= PH_RECORDING;
                    r_tick  <= tick_hit ? '0 : tick_next;
                end else begin
                    // end of dive: once recording, the store reads as empty from here on
                    r_tick <= tick_next;
                    if (r_phase == PH_RECORDING) begin
                        r_phase <= PH_IDLE;
                    end
                end
            end

            if (i_cmd.comp_finish) begin
                r_fill     <= FILL_HALF;
                r_interval <= {r_interval[INTERVAL_W-2:0], 1'b0};
            end

            if (i_cmd.append) begin
                r_fill    <= r_fill + FILL_ONE;
                r_written <= 1'b1;
            end
        end
    end

    assign o_read_value     = r_read_ok ? READ_W'(r_qa) : '0;
    assign o_fill_count     = FILL_OUT_W'(r_fill);
    assign o_interval_ticks = r_interval;
    assign o_recording      = nonidle;
    assign o_sample_written = r_written;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond store depth");

    a_comp_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.comp_finish |=> r_fill == FILL_HALF)
        else $error("compression did not halve fill count");

    a_comp_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.comp_finish |-> (r_interval < INTERVAL_LIMIT) && (r_fill == FILL_FULL))
        else $error("compression without full store or below limit");

    a_written_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_written |-> r_phase == PH_RECORDING)
        else $error("sample written outside recording");
`endif

endmodule

>>> rtl/decimating_sample_recorder.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// item in   start / busy                i_operation, i_in_dive, i_dive_seconds,
//                                       i_depth_decimeters, i_read_index
// result    o_done (one-cycle strobe)   o_read_value, o_fill_count, o_interval_ticks,
//                                       o_recording, o_sample_written
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A read or a plain tick passes the accept, evaluate and strobe states; a tick that stores
// a sample also passes the append state. A tick that compresses a full store runs, before
// the append state, a pass that reads one entry pair per cycle over two memory read ports
// and writes averages on the single write port.
// busy is high from the accept edge until the strobe cycle ends; results cannot be held off.
// Reset (synchronous, active low) empties the store at once through the fill count.

module decimating_sample_recorder import dsr_pkg::*; #(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic                  i_in_dive,
    input  logic [SECONDS_W-1:0]  i_dive_seconds,
    input  logic [DEPTH_W-1:0]    i_depth_decimeters,
    input  logic [INDEX_W-1:0]    i_read_index,
    output logic                  o_done,
    output logic [READ_W-1:0]     o_read_value,
    output logic [FILL_OUT_W-1:0] o_fill_count,
    output logic [INTERVAL_W-1:0] o_interval_ticks,
    output logic                  o_recording,
    output logic                  o_sample_written,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    dsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    dsr_datapath #(
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_operation        (i_operation),
        .i_in_dive          (i_in_dive),
        .i_dive_seconds     (i_dive_seconds),
        .i_depth_decimeters (i_depth_decimeters),
        .i_read_index       (i_read_index),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_read_value       (o_read_value),
        .o_fill_count       (o_fill_count),
        .o_interval_ticks   (o_interval_ticks),
        .o_recording        (o_recording),
        .o_sample_written   (o_sample_written)
    );

endmodule
